[src/tdpc_pkg.sv]
`default_nettype none
package tdpc_pkg;

    // depth registers are unsigned Q15.16 with no sign bit
    localparam int DEPTH_BITS = 31;
    localparam logic [DEPTH_BITS-1:0] NEAR_RESET = 31'd65536;
    localparam logic [DEPTH_BITS-1:0] FAR_RESET  = 31'd6553600;

    // low slice of the edge delta in the split multiply
    localparam int MUL_SPLIT = 16;
    // restoring divide steps per pipeline stage
    localparam int DIV_STEPS = 4;

    typedef enum logic {
        CFG_NEAR = 1'b0,
        CFG_FAR  = 1'b1
    } cfg_reg_e;

    // which vertices lie outside the plane
    typedef enum logic [2:0] {
        CLIP_IN,
        CLIP_A,
        CLIP_B,
        CLIP_C,
        CLIP_AB,
        CLIP_AC,
        CLIP_BC,
        CLIP_OUT
    } clip_case_e;

endpackage
`default_nettype wire

[src/triangle_depth_plane_clip_top.sv]
`default_nettype none
// Clips one triangle against the near or far depth plane and sends out zero, one or two
// triangles, with last set on the final one of each item. Fully pipelined: an item can
// enter every cycle unless the result port holds the pipeline. The shared result port
// sets the sustained rate: an item with one vertex outside sends two triangles in turn
// and holds the next item back while it does, while any other item sends at most one.
// Edge points come from a split multiply followed by a restoring divider retiring 4
// quotient bits per stage. Depth registers are written on the cfg channel, which is
// always ready.
module triangle_depth_plane_clip_top #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [tdpc_pkg::DEPTH_BITS-1:0] cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          func,
    input  wire logic signed [COORD_BITS-1:0]  a_x,
    input  wire logic signed [COORD_BITS-1:0]  a_y,
    input  wire logic signed [COORD_BITS-1:0]  a_z,
    input  wire logic signed [COORD_BITS-1:0]  b_x,
    input  wire logic signed [COORD_BITS-1:0]  b_y,
    input  wire logic signed [COORD_BITS-1:0]  b_z,
    input  wire logic signed [COORD_BITS-1:0]  c_x,
    input  wire logic signed [COORD_BITS-1:0]  c_y,
    input  wire logic signed [COORD_BITS-1:0]  c_z,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_BITS-1:0]       out_a_x,
    output logic signed [COORD_BITS-1:0]       out_a_y,
    output logic signed [COORD_BITS-1:0]       out_a_z,
    output logic signed [COORD_BITS-1:0]       out_b_x,
    output logic signed [COORD_BITS-1:0]       out_b_y,
    output logic signed [COORD_BITS-1:0]       out_b_z,
    output logic signed [COORD_BITS-1:0]       out_c_x,
    output logic signed [COORD_BITS-1:0]       out_c_y,
    output logic signed [COORD_BITS-1:0]       out_c_z,
    output logic                               last
);

    localparam int W  = COORD_BITS;
    localparam int DB = tdpc_pkg::DEPTH_BITS;
    localparam int ZW = ((W > 32) ? W : 32) + 1;
    localparam int MS = tdpc_pkg::MUL_SPLIT;
    localparam int HW = W + 1 - MS;
    localparam int DS = tdpc_pkg::DIV_STEPS;
    localparam int ND = (W + DS - 1) / DS;
    localparam int PW = 2 * W + 1;

    typedef logic signed [W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    typedef struct packed {
        vtx_t                 a;
        vtx_t                 b;
        vtx_t                 c;
        tdpc_pkg::clip_case_e kind;
        logic [DB-1:0]        lim;
    } tri_t;

    // ---------------- configuration ----------------
    logic [DB-1:0] near_reg;
    logic [DB-1:0] far_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= tdpc_pkg::NEAR_RESET;
            far_reg  <= tdpc_pkg::FAR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (tdpc_pkg::cfg_reg_e'(cfg_index))
                tdpc_pkg::CFG_NEAR: near_reg <= cfg_data;
                tdpc_pkg::CFG_FAR:  far_reg  <= cfg_data;
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    logic en;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, f_valid_reg;
    logic dv_reg [ND+1];

    tri_t s1_tri_reg;
    logic s1_near_reg;

    tri_t s2_tri_reg;
    vtx_t s2_i_reg [2];
    vtx_t s2_o_reg [2];

    tri_t         s3_tri_reg;
    logic [W:0]   s3_dmag_reg [4];
    logic         s3_neg_reg  [4];
    coord_t       s3_ival_reg [4];
    logic [W-1:0] s3_num_reg  [2];
    logic [W-1:0] s3_den_reg  [2];

    tri_t              s4_tri_reg;
    logic [W+MS-1:0]   s4_pplo_reg [4];
    logic [W+HW-1:0]   s4_pphi_reg [4];
    logic              s4_neg_reg  [4];
    coord_t            s4_ival_reg [4];
    logic [W-1:0]      s4_den_reg  [2];

    tri_t         dtri_reg  [ND+1];
    logic [W-1:0] dr_reg    [ND+1][4];
    logic [W-1:0] dl_reg    [ND+1][4];
    logic [W-1:0] dden_reg  [ND+1][2];
    logic         dneg_reg  [ND+1][4];
    coord_t       dival_reg [ND+1][4];

    tri_t   f_tri_reg;
    coord_t f_pt_reg [4];

    // ---------------- stage 1: classify and pick edges ----------------
    tdpc_pkg::clip_case_e kind1;
    vtx_t                 i1 [2];
    vtx_t                 o1 [2];
    logic signed [ZW-1:0] lim1, za, zb, zc;
    logic                 oa, ob, oc;

    always_comb
    begin
        lim1 = {{(ZW-DB){1'b0}}, s1_tri_reg.lim};
        za   = {{(ZW-W){s1_tri_reg.a.z[W-1]}}, s1_tri_reg.a.z};
        zb   = {{(ZW-W){s1_tri_reg.b.z[W-1]}}, s1_tri_reg.b.z};
        zc   = {{(ZW-W){s1_tri_reg.c.z[W-1]}}, s1_tri_reg.c.z};
        oa   = s1_near_reg ? (za < lim1) : (za > lim1);
        ob   = s1_near_reg ? (zb < lim1) : (zb > lim1);
        oc   = s1_near_reg ? (zc < lim1) : (zc > lim1);

        unique case ({oa, ob, oc})
            3'b000: kind1 = tdpc_pkg::CLIP_IN;
            3'b100: kind1 = tdpc_pkg::CLIP_A;
            3'b010: kind1 = tdpc_pkg::CLIP_B;
            3'b001: kind1 = tdpc_pkg::CLIP_C;
            3'b110: kind1 = tdpc_pkg::CLIP_AB;
            3'b101: kind1 = tdpc_pkg::CLIP_AC;
            3'b011: kind1 = tdpc_pkg::CLIP_BC;
            3'b111: kind1 = tdpc_pkg::CLIP_OUT;
        endcase

        // each edge runs from its inside vertex toward its outside vertex
        unique case (kind1)
            tdpc_pkg::CLIP_A:
            begin
                i1[0] = s1_tri_reg.b; o1[0] = s1_tri_reg.a;
                i1[1] = s1_tri_reg.c; o1[1] = s1_tri_reg.a;
            end
            tdpc_pkg::CLIP_B:
            begin
                i1[0] = s1_tri_reg.a; o1[0] = s1_tri_reg.b;
                i1[1] = s1_tri_reg.c; o1[1] = s1_tri_reg.b;
            end
            tdpc_pkg::CLIP_C:
            begin
                i1[0] = s1_tri_reg.b; o1[0] = s1_tri_reg.c;
                i1[1] = s1_tri_reg.a; o1[1] = s1_tri_reg.c;
            end
            tdpc_pkg::CLIP_AB:
            begin
                i1[0] = s1_tri_reg.c; o1[0] = s1_tri_reg.a;
                i1[1] = s1_tri_reg.c; o1[1] = s1_tri_reg.b;
            end
            tdpc_pkg::CLIP_AC:
            begin
                i1[0] = s1_tri_reg.b; o1[0] = s1_tri_reg.a;
                i1[1] = s1_tri_reg.b; o1[1] = s1_tri_reg.c;
            end
            tdpc_pkg::CLIP_BC:
            begin
                i1[0] = s1_tri_reg.a; o1[0] = s1_tri_reg.b;
                i1[1] = s1_tri_reg.a; o1[1] = s1_tri_reg.c;
            end
            default:
            begin
                i1[0] = s1_tri_reg.a; o1[0] = s1_tri_reg.b;
                i1[1] = s1_tri_reg.a; o1[1] = s1_tri_reg.c;
            end
        endcase
    end

    // ---------------- stage 2: deltas and magnitudes ----------------
    logic [W:0]   dmag2 [4];
    logic         neg2  [4];
    coord_t       ival2 [4];
    logic [W-1:0] num2  [2];
    logic [W-1:0] den2  [2];

    always_comb
    begin
        logic signed [W:0]    dx, dy;
        logic signed [ZW-1:0] lim2, iz, oz, nm, dn;
        lim2 = {{(ZW-DB){1'b0}}, s2_tri_reg.lim};
        for (int e = 0; e < 2; e++)
        begin
            dx = {s2_o_reg[e].x[W-1], s2_o_reg[e].x} - {s2_i_reg[e].x[W-1], s2_i_reg[e].x};
            dy = {s2_o_reg[e].y[W-1], s2_o_reg[e].y} - {s2_i_reg[e].y[W-1], s2_i_reg[e].y};
            iz = {{(ZW-W){s2_i_reg[e].z[W-1]}}, s2_i_reg[e].z};
            oz = {{(ZW-W){s2_o_reg[e].z[W-1]}}, s2_o_reg[e].z};
            nm = lim2 - iz;
            dn = oz - iz;
            dmag2[2*e]     = dx[W] ? -dx : dx;
            dmag2[2*e+1]   = dy[W] ? -dy : dy;
            neg2[2*e]      = dx[W];
            neg2[2*e+1]    = dy[W];
            ival2[2*e]     = s2_i_reg[e].x;
            ival2[2*e+1]   = s2_i_reg[e].y;
            // |num| <= |den| < 2^W, so the low bits hold the whole magnitude
            num2[e] = nm[ZW-1] ? W'(-nm) : nm[W-1:0];
            den2[e] = dn[ZW-1] ? W'(-dn) : dn[W-1:0];
        end
    end

    // ---------------- stage 3: partial products ----------------
    logic [W+MS-1:0] pplo3 [4];
    logic [W+HW-1:0] pphi3 [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            pplo3[l] = (W+MS)'(s3_num_reg[l/2]) * (W+MS)'(s3_dmag_reg[l][MS-1:0]);
            pphi3[l] = (W+HW)'(s3_num_reg[l/2]) * (W+HW)'(s3_dmag_reg[l][W:MS]);
        end
    end

    // ---------------- stage 4: product sum ----------------
    logic [PW-1:0] prod4 [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            prod4[l] = (PW'(s4_pphi_reg[l]) << MS) + PW'(s4_pplo_reg[l]);
        end
    end

    // ---------------- divider stages ----------------
    logic [W-1:0] dr_next [ND][4];
    logic [W-1:0] dl_next [ND][4];

    always_comb
    begin
        logic [W-1:0] r;
        logic [W-1:0] lo;
        logic [W:0]   t;
        for (int k = 0; k < ND; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                r  = dr_reg[k][l];
                lo = dl_reg[k][l];
                for (int j = 0; j < DS; j++)
                begin
                    if (k * DS + j < W)
                    begin
                        t  = {r, lo[W-1]};
                        lo = {lo[W-2:0], 1'b0};
                        if (t >= {1'b0, dden_reg[k][l/2]})
                        begin
                            t     = t - {1'b0, dden_reg[k][l/2]};
                            lo[0] = 1'b1;
                        end
                        r = t[W-1:0];
                    end
                end
                dr_next[k][l] = r;
                dl_next[k][l] = lo;
            end
        end
    end

    // ---------------- final: apply sign, add to inside vertex ----------------
    coord_t pt_next [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            pt_next[l] = dival_reg[ND][l] +
                         (dneg_reg[ND][l] ? -coord_t'(dl_reg[ND][l]) : coord_t'(dl_reg[ND][l]));
        end
    end

    // ---------------- output sequencing ----------------
    logic   out_valid_reg, out_valid_next;
    logic   out_last_reg;
    logic   phase_reg, phase_next;
    vtx_t   out_v_reg [3];
    vtx_t   tv [3];
    vtx_t   e1, e2;
    coord_t limw;
    logic   two_res, no_res, out_free, load, consume;

    always_comb
    begin
        limw = coord_t'(W'({{(ZW-DB){1'b0}}, f_tri_reg.lim}));
        e1   = '{x: f_pt_reg[0], y: f_pt_reg[1], z: limw};
        e2   = '{x: f_pt_reg[2], y: f_pt_reg[3], z: limw};
        two_res = 1'b0;
        no_res  = 1'b0;
        tv[0] = f_tri_reg.a;
        tv[1] = f_tri_reg.b;
        tv[2] = f_tri_reg.c;
        unique case (f_tri_reg.kind)
            tdpc_pkg::CLIP_IN:
            begin
            end
            tdpc_pkg::CLIP_A:
            begin
                two_res = 1'b1;
                if (phase_reg)
                begin
                    tv[0] = e2; tv[1] = e1;
                end
                else
                begin
                    tv[0] = e1;
                end
            end
            tdpc_pkg::CLIP_B:
            begin
                two_res = 1'b1;
                if (phase_reg)
                begin
                    tv[0] = e1; tv[1] = e2;
                end
                else
                begin
                    tv[1] = e1;
                end
            end
            tdpc_pkg::CLIP_C:
            begin
                two_res = 1'b1;
                if (phase_reg)
                begin
                    tv[1] = e1; tv[2] = e2;
                end
                else
                begin
                    tv[2] = e1;
                end
            end
            tdpc_pkg::CLIP_AB:
            begin
                tv[0] = e1; tv[1] = e2;
            end
            tdpc_pkg::CLIP_AC:
            begin
                tv[0] = e1; tv[2] = e2;
            end
            tdpc_pkg::CLIP_BC:
            begin
                tv[1] = e1; tv[2] = e2;
            end
            tdpc_pkg::CLIP_OUT:
            begin
                no_res = 1'b1;
            end
        endcase

        out_free   = !out_valid_reg || out_ready;
        load       = 1'b0;
        consume    = 1'b0;
        phase_next = phase_reg;
        if (f_valid_reg)
        begin
            if (no_res)
            begin
                consume = 1'b1;
            end
            else if (out_free)
            begin
                load = 1'b1;
                if (phase_reg || !two_res)
                begin
                    consume    = 1'b1;
                    phase_next = 1'b0;
                end
                else
                begin
                    phase_next = 1'b1;
                end
            end
        end
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    assign en       = !f_valid_reg || consume;
    assign in_ready = en;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            f_valid_reg   <= 1'b0;
            for (int k = 0; k <= ND; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            if (en)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                dv_reg[0]    <= s4_valid_reg;
                for (int k = 0; k < ND; k++)
                begin
                    dv_reg[k+1] <= dv_reg[k];
                end
                f_valid_reg  <= dv_reg[ND];
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_v_reg    <= tv;
            out_last_reg <= consume;
        end
        if (en)
        begin
            s1_tri_reg.a    <= '{x: a_x, y: a_y, z: a_z};
            s1_tri_reg.b    <= '{x: b_x, y: b_y, z: b_z};
            s1_tri_reg.c    <= '{x: c_x, y: c_y, z: c_z};
            s1_tri_reg.kind <= tdpc_pkg::CLIP_IN;
            s1_tri_reg.lim  <= func ? near_reg : far_reg;
            s1_near_reg     <= func;

            s2_tri_reg <= '{a: s1_tri_reg.a, b: s1_tri_reg.b, c: s1_tri_reg.c,
                            kind: kind1, lim: s1_tri_reg.lim};
            s2_i_reg   <= i1;
            s2_o_reg   <= o1;

            s3_tri_reg  <= s2_tri_reg;
            s3_dmag_reg <= dmag2;
            s3_neg_reg  <= neg2;
            s3_ival_reg <= ival2;
            s3_num_reg  <= num2;
            s3_den_reg  <= den2;

            s4_tri_reg  <= s3_tri_reg;
            s4_pplo_reg <= pplo3;
            s4_pphi_reg <= pphi3;
            s4_neg_reg  <= s3_neg_reg;
            s4_ival_reg <= s3_ival_reg;
            s4_den_reg  <= s3_den_reg;

            // product below den * 2^W, so the quotient fits W bits
            dtri_reg[0]  <= s4_tri_reg;
            dden_reg[0]  <= s4_den_reg;
            dneg_reg[0]  <= s4_neg_reg;
            dival_reg[0] <= s4_ival_reg;
            for (int l = 0; l < 4; l++)
            begin
                dr_reg[0][l] <= prod4[l][2*W-1:W];
                dl_reg[0][l] <= prod4[l][W-1:0];
            end
            for (int k = 0; k < ND; k++)
            begin
                dtri_reg[k+1]  <= dtri_reg[k];
                dden_reg[k+1]  <= dden_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dival_reg[k+1] <= dival_reg[k];
                dr_reg[k+1]    <= dr_next[k];
                dl_reg[k+1]    <= dl_next[k];
            end

            f_tri_reg <= dtri_reg[ND];
            f_pt_reg  <= pt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign last      = out_last_reg;
    assign out_a_x   = out_v_reg[0].x;
    assign out_a_y   = out_v_reg[0].y;
    assign out_a_z   = out_v_reg[0].z;
    assign out_b_x   = out_v_reg[1].x;
    assign out_b_y   = out_v_reg[1].y;
    assign out_b_z   = out_v_reg[1].z;
    assign out_c_x   = out_v_reg[2].x;
    assign out_c_y   = out_v_reg[2].y;
    assign out_c_z   = out_v_reg[2].z;

    // ---------------- assertions ----------------
    // second triangle of a split is pending only while its item sits in the final stage
    assert property (@(posedge clk) disable iff (!rst_n) phase_reg |-> f_valid_reg)
        else $error("split phase set with no item in final stage");

    // a taken non-final triangle is always followed right away by the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !out_last_reg) |=> (out_valid_reg && out_last_reg))
        else $error("first triangle of split not followed by the second");

    // restoring divide leaves a remainder below the divisor, checked on lane 0 of live items with two vertices outside
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[ND] && (dtri_reg[ND].kind == tdpc_pkg::CLIP_AB ||
                        dtri_reg[ND].kind == tdpc_pkg::CLIP_AC ||
                        dtri_reg[ND].kind == tdpc_pkg::CLIP_BC))
        |-> (dr_reg[ND][0] < dden_reg[ND][0]))
        else $error("divider remainder not below divisor");

    // an accepted item shows up in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted item lost at pipeline entry");

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;

    typedef struct packed {
        logic            fn;
        logic [8:0][31:0] crd;   // a.xyz, b.xyz, c.xyz
    } tri_item_t;

    typedef struct packed {
        logic [8:0][31:0] crd;
        logic            fin;
    } tri_out_t;

    localparam longint DEPTH_MAX = 64'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [tdpc_pkg::DEPTH_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = 1'b0;
    logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
    logic signed [31:0] c_x = 0, c_y = 0, c_z = 0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
    logic signed [31:0] out_c_x, out_c_y, out_c_z;
    logic last;

    tri_item_t pending_tris[$];
    tri_out_t  clipped_tris[$];
    tri_item_t cur_tri;
    longint    near_lim = 65536;
    longint    far_lim  = 6553600;
    int        errors = 0;
    int        in_gap = 0;
    int        out_stall = 0;
    bit        quiet = 1'b0;

    triangle_depth_plane_clip_top #(.COORD_BITS(32)) DUT (.*);

    always #1 clk = ~clk;

    function automatic longint crd_of(tri_item_t t, int v, int k);
        return longint'($signed(t.crd[3*v+k]));
    endfunction

    // point on edge from inside vertex i toward outside vertex o, at depth lim
    function automatic logic [2:0][31:0] edge_pt(tri_item_t t, longint lim, int i, int o);
        logic [2:0][31:0] p;
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        longint num, den;
        num = lim - crd_of(t, i, 2);
        den = crd_of(t, o, 2) - crd_of(t, i, 2);
        for (int k = 0; k < 3; k++)
        begin
            if (den == 0)
                p[k] = t.crd[3*i+k];
            else
            begin
                prod = crd_of(t, o, k) - crd_of(t, i, k);
                prod = prod * num;
                quo = prod / den;
                p[k] = 32'(crd_of(t, i, k) + longint'(quo));
            end
        end
        return p;
    endfunction

    function automatic logic [2:0][31:0] vert(tri_item_t t, int v);
        return {t.crd[3*v+2], t.crd[3*v+1], t.crd[3*v]};
    endfunction

    function automatic void push_tri(logic [2:0][31:0] p, logic [2:0][31:0] q,
                                     logic [2:0][31:0] r, logic fin);
        tri_out_t e;
        e.crd = {r, q, p};
        e.fin = fin;
        clipped_tris.push_back(e);
    endfunction

    function automatic void clip_tri(tri_item_t t);
        longint lim;
        logic [2:0] outside;
        lim = t.fn ? near_lim : far_lim;
        for (int v = 0; v < 3; v++)
            outside[v] = t.fn ? (crd_of(t, v, 2) < lim) : (crd_of(t, v, 2) > lim);
        case (outside)
            3'b000: push_tri(vert(t, 0), vert(t, 1), vert(t, 2), 1'b1);
            3'b001:
            begin
                push_tri(edge_pt(t, lim, 1, 0), vert(t, 1), vert(t, 2), 1'b0);
                push_tri(edge_pt(t, lim, 2, 0), edge_pt(t, lim, 1, 0), vert(t, 2), 1'b1);
            end
            3'b010:
            begin
                push_tri(vert(t, 0), edge_pt(t, lim, 0, 1), vert(t, 2), 1'b0);
                push_tri(edge_pt(t, lim, 0, 1), edge_pt(t, lim, 2, 1), vert(t, 2), 1'b1);
            end
            3'b100:
            begin
                push_tri(vert(t, 0), vert(t, 1), edge_pt(t, lim, 1, 2), 1'b0);
                push_tri(vert(t, 0), edge_pt(t, lim, 1, 2), edge_pt(t, lim, 0, 2), 1'b1);
            end
            3'b011: push_tri(edge_pt(t, lim, 2, 0), edge_pt(t, lim, 2, 1), vert(t, 2), 1'b1);
            3'b101: push_tri(edge_pt(t, lim, 1, 0), vert(t, 1), edge_pt(t, lim, 1, 2), 1'b1);
            3'b110: push_tri(vert(t, 0), edge_pt(t, lim, 0, 1), edge_pt(t, lim, 0, 2), 1'b1);
            default: ;
        endcase
    endfunction

    // depth near the active plane: 0 inside, 1 outside, 2 on plane, 3 anywhere
    function automatic logic [31:0] pick_z(logic fn, int mode);
        longint lim, off, z;
        lim = fn ? near_lim : far_lim;
        off = ($urandom_range(0, 3) == 0) ? longint'($urandom) : $urandom_range(1, 1 << 20);
        if (off == 0)
            off = 1;
        case (mode)
            0: z = fn ? lim + off : lim - off;
            1: z = fn ? lim - off : lim + off;
            2: z = lim;
            default: z = longint'($signed($urandom));
        endcase
        if (z > 64'sh7FFF_FFFF)
            z = 64'sh7FFF_FFFF;
        if (z < -64'sh8000_0000)
            z = -64'sh8000_0000;
        return 32'(z);
    endfunction

    function automatic tri_item_t make_tri(logic fn, int ma, int mb, int mc);
        tri_item_t t;
        int m[3];
        m = '{ma, mb, mc};
        t.fn = fn;
        for (int v = 0; v < 3; v++)
        begin
            for (int k = 0; k < 2; k++)
                t.crd[3*v+k] = $urandom_range(0, 1) ? $urandom
                                                    : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            t.crd[3*v+2] = pick_z(fn, m[v]);
        end
        return t;
    endfunction

    task automatic queue_directed();
        tri_item_t t;
        for (int fn = 0; fn < 2; fn++)
        begin
            for (int mask = 0; mask < 8; mask++)
                pending_tris.push_back(make_tri(fn[0], int'(mask[0]), int'(mask[1]),
                                                int'(mask[2])));
            pending_tris.push_back(make_tri(fn[0], 2, 1, 2));
            t = make_tri(fn[0], 1, 0, 0);
            t.crd[0] = 32'h8000_0000;
            t.crd[1] = 32'h7FFF_FFFF;
            t.crd[3] = 32'h7FFF_FFFF;
            t.crd[4] = 32'h8000_0000;
            t.crd[6] = 32'hFFFF_FFFF;
            pending_tris.push_back(t);
        end
        t = make_tri(1'b0, 3, 3, 3);
        t.crd[2] = 32'h8000_0000;
        t.crd[5] = 32'h7FFF_FFFF;
        pending_tris.push_back(t);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_tris.push_back(make_tri(1'($urandom_range(0, 1)), $urandom_range(0, 3),
                                            $urandom_range(0, 3), $urandom_range(0, 3)));
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_tris.size() != 0 || in_valid || clipped_tris.size() != 0);
        // items that cull everything leave nothing to wait on
        repeat (20) @(negedge clk);
    endtask

    task automatic write_depth(tdpc_pkg::cfg_reg_e idx, longint val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[tdpc_pkg::DEPTH_BITS-1:0];
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tdpc_pkg::CFG_NEAR)
            near_lim = val;
        else
            far_lim = val;
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            clip_tri(cur_tri);
        if (in_valid && !in_ready)
            ;
        else if (in_gap > 0)
        begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_tris.size() != 0 && rst_n)
        begin
            cur_tri = pending_tris.pop_front();
            in_valid <= 1'b1;
            func <= cur_tri.fn;
            {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x} <= cur_tri.crd;
            if (!quiet && $urandom_range(0, 9) == 0)
                in_gap <= $urandom_range(1, 8);
        end
        else
            in_valid <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        tri_out_t got, want;
        if (out_valid && out_ready)
        begin
            got.crd = {out_c_z, out_c_y, out_c_x, out_b_z, out_b_y, out_b_x,
                       out_a_z, out_a_y, out_a_x};
            got.fin = last;
            if (clipped_tris.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected triangle %h", got);
            end
            else
            begin
                want = clipped_tris.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got.crd[k] != want.crd[k])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("coord %0d: expected %h got %h", k, want.crd[k], got.crd[k]);
                    end
                if (got.fin != want.fin)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("last: expected %b got %b", want.fin, got.fin);
                end
            end
        end
        if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        queue_directed();
        queue_random(150);
        wait_idle();

        write_depth(tdpc_pkg::CFG_NEAR, 0);
        write_depth(tdpc_pkg::CFG_FAR, DEPTH_MAX);
        queue_directed();
        queue_random(100);
        wait_idle();

        write_depth(tdpc_pkg::CFG_NEAR, DEPTH_MAX);
        write_depth(tdpc_pkg::CFG_FAR, 0);
        queue_directed();
        queue_random(100);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_depth(tdpc_pkg::CFG_NEAR, (p[0]) ? longint'($urandom & 32'h7FFF_FFFF)
                                                   : longint'($urandom_range(0, 1 << 20)));
            write_depth(tdpc_pkg::CFG_FAR, (p[1]) ? longint'($urandom & 32'h7FFF_FFFF)
                                                  : longint'($urandom_range(0, 1 << 26)));
            queue_directed();
            queue_random(200);
            wait_idle();
        end

        write_depth(tdpc_pkg::CFG_NEAR, 65536);
        write_depth(tdpc_pkg::CFG_FAR, 6553600);
        quiet = 1'b1;
        queue_random(150);
        wait_idle();

        errors += clipped_tris.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/tdpc_pkg.sv
src/triangle_depth_plane_clip_top.sv
verif/tb_top.sv
